FILE: hdl/utf8v_pkg.sv
package utf8v_pkg;

    // Width of the length limit register.
    localparam int LEN_W = 25;
    localparam logic [LEN_W-1:0] MAX_LENGTH_RESET = 25'd1048576;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_EMPTY = 3'd1,
        ST_LONG  = 3'd2,
        ST_CTRL  = 3'd3,
        ST_LEAD  = 3'd4,
        ST_CONT  = 3'd5,
        ST_CP    = 3'd6,
        ST_TRUNC = 3'd7
    } status_t;

    localparam logic [7:0] LEAD2_LO = 8'hC2;
    localparam logic [7:0] LEAD2_HI = 8'hDF;
    localparam logic [7:0] LEAD3_LO = 8'hE0;
    localparam logic [7:0] LEAD3_HI = 8'hEF;
    localparam logic [7:0] LEAD4_LO = 8'hF0;
    localparam logic [7:0] LEAD4_HI = 8'hF4;
    localparam logic [7:0] CONT_MASK = 8'hC0;
    localparam logic [7:0] CONT_TAG  = 8'h80;
    localparam logic [7:0] BYTE_DEL  = 8'h7F;
    localparam logic [7:0] BYTE_SPACE = 8'h20;
    localparam logic [7:0] BYTE_TAB  = 8'h09;
    localparam logic [7:0] BYTE_LF   = 8'h0A;
    localparam logic [7:0] BYTE_CR   = 8'h0D;

    localparam logic [20:0] CP_MIN3      = 21'h000800;
    localparam logic [20:0] CP_MIN4      = 21'h010000;
    localparam logic [20:0] CP_SURR_LO   = 21'h00D800;
    localparam logic [20:0] CP_SURR_HI   = 21'h00DFFF;
    localparam logic [20:0] CP_MAX       = 21'h10FFFF;

    // Decoder state carried from byte to byte within one text.
    typedef struct packed {
        logic [1:0]  pend;
        logic [2:0]  seq_len;
        logic [20:0] cp;
        status_t     err;
    } text_state_t;

endpackage

FILE: hdl/utf8v_decoder.sv
module utf8v_decoder
    import utf8v_pkg::*;
(
    input  logic        has_byte,
    input  logic [7:0]  data_byte,
    input  text_state_t state_in,
    output text_state_t state_out
);

    logic        is_ctrl;
    logic [20:0] cp_shift;
    logic        cp_bad;

    assign is_ctrl = (data_byte == 8'h00) || (data_byte == BYTE_DEL) ||
                     ((data_byte < BYTE_SPACE) && (data_byte != BYTE_TAB) &&
                      (data_byte != BYTE_LF) && (data_byte != BYTE_CR));

    assign cp_shift = {state_in.cp[14:0], data_byte[5:0]};

    assign cp_bad = ((state_in.seq_len == 3'd3) && (cp_shift < CP_MIN3)) ||
                    ((state_in.seq_len == 3'd4) && (cp_shift < CP_MIN4)) ||
                    ((cp_shift >= CP_SURR_LO) && (cp_shift <= CP_SURR_HI)) ||
                    (cp_shift > CP_MAX);

    always_comb begin
        state_out = state_in;
        if (has_byte && (state_in.err == ST_OK)) begin
            if (state_in.pend == 2'd0) begin
                // Lead byte position.
                if (is_ctrl) begin
                    state_out.err = ST_CTRL;
                end else if (data_byte < CONT_TAG) begin
                    state_out = state_in;
                end else if ((data_byte >= LEAD2_LO) && (data_byte <= LEAD2_HI)) begin
                    state_out.seq_len = 3'd2;
                    state_out.pend    = 2'd1;
                    state_out.cp      = {16'd0, data_byte[4:0]};
                end else if ((data_byte >= LEAD3_LO) && (data_byte <= LEAD3_HI)) begin
                    state_out.seq_len = 3'd3;
                    state_out.pend    = 2'd2;
                    state_out.cp      = {17'd0, data_byte[3:0]};
                end else if ((data_byte >= LEAD4_LO) && (data_byte <= LEAD4_HI)) begin
                    state_out.seq_len = 3'd4;
                    state_out.pend    = 2'd3;
                    state_out.cp      = {18'd0, data_byte[2:0]};
                end else begin
                    state_out.err = ST_LEAD;
                end
            end else if ((data_byte & CONT_MASK) != CONT_TAG) begin
                state_out.err = ST_CONT;
            end else begin
                state_out.pend = state_in.pend - 2'd1;
                state_out.cp   = cp_shift;
                if (state_in.pend == 2'd1) begin
                    if (cp_bad) begin
                        state_out.err = ST_CP;
                    end
                    state_out.seq_len = 3'd0;
                    state_out.cp      = 21'd0;
                end
            end
        end
    end

endmodule

FILE: hdl/utf8_text_validator_top.sv
// UTF-8 text validator. A text arrives one byte per input transaction, with
// s_last marking its end; s_has_byte low lets an end marker carry no byte.
// Exactly one verdict transaction (m_text_ok, m_status) leaves for each input
// transaction with s_last high, and none for any other. The status reports an
// empty text first, then a text longer than the max_length register, then the
// first content error in stream order (control byte, bad lead, bad
// continuation, bad code point, truncated sequence). One byte is taken in
// every cycle unless the result register stalls; a byte is staged in the
// input register, and the closing byte's verdict is loaded into the result
// register, which drives m_valid, once that register is free or being
// drained. The sustained rate of one transaction per cycle is set by the
// combinational decode between the input and result registers; it drops
// only while the result register holds a verdict that m_ready has not yet
// taken. The user must write the limit through cfg_wr_en/cfg_wr_data only
// while no text is in flight; the block does not enforce it.
module utf8_text_validator_top
    import utf8v_pkg::*;
#(
    parameter int COUNT_WIDTH = 25
) (
    input  logic             aclk,
    input  logic             aresetn,

    input  logic             cfg_wr_en,
    input  logic [LEN_W-1:0] cfg_wr_data,

    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_has_byte,
    input  logic [7:0]       s_data_byte,
    input  logic             s_last,

    output logic             m_valid,
    input  logic             m_ready,
    output logic             m_text_ok,
    output logic [2:0]       m_status
);

    // Compare width that holds the limit plus one as well as the full count.
    localparam int CMP_W = ((COUNT_WIDTH > LEN_W) ? COUNT_WIDTH : LEN_W) + 1;

    logic [LEN_W-1:0] max_length_reg;

    // Input register.
    logic       in_valid_reg;
    logic       in_has_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // Per-text state.
    text_state_t            state_reg;
    text_state_t            state_next;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;

    // Result register.
    logic    out_valid_reg;
    status_t out_status_reg;
    status_t status_next;

    logic             advance;
    logic [CMP_W-1:0] count_ext;
    logic [CMP_W-1:0] count_next_ext;
    logic [CMP_W-1:0] max_ext;
    logic [CMP_W-1:0] full_ext;
    logic [CMP_W-1:0] ceiling;

    // The staged byte moves on whenever the result register is free or being
    // drained this cycle; the input register refills in the same cycle.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign m_valid   = out_valid_reg;
    assign m_status  = out_status_reg;
    assign m_text_ok = (out_status_reg == ST_OK);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_length_reg <= MAX_LENGTH_RESET;
        end else if (cfg_wr_en) begin
            max_length_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_has_reg  <= s_has_byte;
            in_byte_reg <= s_data_byte;
            in_last_reg <= s_last;
        end
    end

    utf8v_decoder u_decoder (
        .has_byte  (in_has_reg),
        .data_byte (in_byte_reg),
        .state_in  (state_reg),
        .state_out (state_next)
    );

    // The byte count stops one past the limit, or at its own all-ones value
    // when the limit is that large.
    assign count_ext = {{(CMP_W-COUNT_WIDTH){1'b0}}, count_reg};
    assign max_ext   = {{(CMP_W-LEN_W){1'b0}}, max_length_reg};
    assign full_ext  = {{(CMP_W-COUNT_WIDTH){1'b0}}, {COUNT_WIDTH{1'b1}}};
    assign ceiling   = ((max_ext + 1'b1) > full_ext) ? full_ext : (max_ext + 1'b1);

    always_comb begin
        count_next = count_reg;
        if (in_has_reg && (count_ext < ceiling)) begin
            count_next = count_reg + 1'b1;
        end
    end

    assign count_next_ext = {{(CMP_W-COUNT_WIDTH){1'b0}}, count_next};

    // Verdict priority: empty, then too long, then the first content error,
    // then a sequence still open at the end.
    always_comb begin
        priority if (count_next == '0) begin
            status_next = ST_EMPTY;
        end else if (count_next_ext > max_ext) begin
            status_next = ST_LONG;
        end else if (state_next.err != ST_OK) begin
            status_next = state_next.err;
        end else if (state_next.pend != 2'd0) begin
            status_next = ST_TRUNC;
        end else begin
            status_next = ST_OK;
        end
    end

    // A verdict clears the text state for the next text.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
            count_reg <= '0;
        end else if (advance) begin
            if (in_last_reg) begin
                state_reg <= '0;
                count_reg <= '0;
            end else begin
                state_reg <= state_next;
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_last_reg;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) begin
            out_status_reg <= status_next;
        end
    end

endmodule

FILE: hdl/utf8v_checker.sv
module utf8v_checker
    import utf8v_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       s_last,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_text_ok,
    input logic [2:0] m_status
);

    // Texts ended at the input whose verdict has not yet been taken.
    logic [2:0] open_reg;
    logic [2:0] open_next;

    always_comb begin
        open_next = open_reg;
        if (s_valid && s_ready && s_last) begin
            open_next = open_next + 3'd1;
        end
        if (m_valid && m_ready) begin
            open_next = open_next - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg <= 3'd0;
        end else begin
            open_reg <= open_next;
        end
    end

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status))
        else $error("verdict dropped or changed while stalled");

    a_ok_matches_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_text_ok == (m_status == ST_OK)))
        else $error("text_ok disagrees with status");

    a_no_invented_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (open_reg != 3'd0))
        else $error("verdict without an ended text");

    a_bounded_backlog: assert property (@(posedge aclk) disable iff (!aresetn)
        open_reg <= 3'd2)
        else $error("more ended texts in flight than stages hold");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("verdict shown right after reset");

endmodule

bind utf8_text_validator_top utf8v_checker u_utf8v_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_last    (s_last),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_text_ok (m_text_ok),
    .m_status  (m_status)
);
